// ===== rtl/nolt_pkg.sv =====
// nolt_pkg: types, codes and sizes shared by the nearest-open-location table.
// No dependencies; every other file of the block but nolt_stream_if imports it.

package nolt_pkg;

	localparam int NOLT_CAPACITY = 64;
	localparam int COORD_W       = 16;
	localparam int DIFF_W        = COORD_W + 1;
	localparam int MAG_W         = COORD_W;
	localparam int DIST_W        = 35;
	localparam int SQ_TERMS      = 3;

	typedef enum logic [2:0] {
		ST_ADDED  = 3'd0,
		ST_KNOWN  = 3'd1,
		ST_FULL   = 3'd2,
		ST_POPPED = 3'd3,
		ST_EMPTY  = 3'd4
	} status_t;

	typedef enum logic {
		CMD_ADD = 1'b0,
		CMD_POP = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SQ,
		S_SCAN,
		S_COMMIT
	} ctrl_state_t;

	typedef struct packed {
		logic               cmd;
		logic signed [15:0] point_x;
		logic signed [15:0] point_y;
		logic signed [15:0] point_z;
		logic signed [15:0] goal_x;
		logic signed [15:0] goal_y;
		logic signed [15:0] goal_z;
	} in_item_t;

	typedef struct packed {
		status_t            status;
		logic signed [15:0] out_x;
		logic signed [15:0] out_y;
		logic signed [15:0] out_z;
	} out_item_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
		logic [DIST_W-1:0]  distance;
	} slot_t;

	// controller -> datapath
	typedef struct packed {
		logic    load_in;
		logic    sq_en;
		logic [1:0] sq_sel;
		logic    scan_issue;
		logic    commit_add;
		logic    commit_pop;
		logic    out_load;
		status_t out_status;
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic op_pop;
		logic scan_end;
		logic hit;
		logic found;
		logic full;
		logic out_busy;
	} dp_stat_t;

endpackage

// ===== rtl/nolt_stream_if.sv =====
// nolt_stream_if: valid/ready channel carrying one word of type T.
// Payload types come from nolt_pkg.

interface nolt_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/nolt_datapath.sv =====
// nolt_datapath: slot memory, open-flag memory, distance accumulator,
// scan/compare stage and output register. Driven by nolt_ctrl; uses nolt_pkg.

module nolt_datapath
	import nolt_pkg::*;
#(
	parameter int CAPACITY = NOLT_CAPACITY
) (
	input  logic      clk,
	input  logic      arst_n,
	input  ctrl_cmd_t cmd,
	input  in_item_t  in_data,
	input  logic      out_ready,
	output dp_stat_t  stat,
	output out_item_t out_data,
	output logic      out_valid
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);

	slot_t slot_mem [CAPACITY];
	logic  open_mem [CAPACITY];

	logic                     op_pop_q;
	logic [COORD_W-1:0]       px_q, py_q, pz_q;
	logic signed [DIFF_W-1:0] dx_q, dy_q, dz_q;
	logic [DIST_W-1:0]        dist_acc_q;
	logic [CNT_W-1:0]         used_q;
	logic [CNT_W-1:0]         rd_idx_q;

	logic                     valid_s1;
	logic [IDX_W-1:0]         idx_s1;
	slot_t                    rd_s1;
	logic                     open_s1;

	logic                     hit_q, found_q;
	logic [DIST_W-1:0]        best_dist_q;
	logic [IDX_W-1:0]         best_idx_q;
	logic [COORD_W-1:0]       best_x_q, best_y_q, best_z_q;

	out_item_t                out_q;
	logic                     out_valid_q;

	logic signed [DIFF_W-1:0] d_sel;
	logic [MAG_W-1:0]         mag;
	logic [2*MAG_W-1:0]       sq;
	logic                     match_s1, better_s1;
	logic [IDX_W-1:0]         wr_idx;

	// one squarer, shared across the three axes
	always_comb begin
		case (cmd.sq_sel)
			2'd0:    d_sel = dx_q;
			2'd1:    d_sel = dy_q;
			default: d_sel = dz_q;
		endcase
		mag = d_sel[DIFF_W-1] ? MAG_W'(-d_sel) : MAG_W'(d_sel);
		sq  = mag * mag;
	end

	assign match_s1  = valid_s1 && rd_s1.x == px_q && rd_s1.y == py_q && rd_s1.z == pz_q;
	assign better_s1 = valid_s1 && open_s1 && (!found_q || rd_s1.distance < best_dist_q);
	assign wr_idx    = used_q[IDX_W-1:0];

	// slot and open-flag memories
	always_ff @(posedge clk) begin
		if (cmd.commit_add) begin
			slot_mem[wr_idx] <= '{x: px_q, y: py_q, z: pz_q, distance: dist_acc_q};
		end
		if (cmd.scan_issue) begin
			rd_s1 <= slot_mem[rd_idx_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit_add) begin
			open_mem[wr_idx] <= 1'b1;
		end else if (cmd.commit_pop) begin
			open_mem[best_idx_q] <= 1'b0;
		end
		if (cmd.scan_issue) begin
			open_s1 <= open_mem[rd_idx_q[IDX_W-1:0]];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			rd_idx_q    <= '0;
			valid_s1    <= 1'b0;
			hit_q       <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1 <= cmd.scan_issue;
			if (cmd.load_in) begin
				rd_idx_q <= '0;
				hit_q    <= 1'b0;
				found_q  <= 1'b0;
			end else begin
				if (cmd.scan_issue) begin
					rd_idx_q <= rd_idx_q + 1'b1;
				end
				if (match_s1) begin
					hit_q <= 1'b1;
				end
				if (better_s1) begin
					found_q <= 1'b1;
				end
			end
			if (cmd.commit_add) begin
				used_q <= used_q + 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.scan_issue) begin
			idx_s1 <= rd_idx_q[IDX_W-1:0];
		end
		if (cmd.load_in) begin
			op_pop_q   <= in_data.cmd;
			px_q       <= in_data.point_x;
			py_q       <= in_data.point_y;
			pz_q       <= in_data.point_z;
			dx_q       <= DIFF_W'(in_data.goal_x) - DIFF_W'(in_data.point_x);
			dy_q       <= DIFF_W'(in_data.goal_y) - DIFF_W'(in_data.point_y);
			dz_q       <= DIFF_W'(in_data.goal_z) - DIFF_W'(in_data.point_z);
			dist_acc_q <= '0;
		end else if (cmd.sq_en) begin
			dist_acc_q <= dist_acc_q + DIST_W'(sq);
		end
		if (!cmd.load_in && better_s1) begin
			best_dist_q <= rd_s1.distance;
			best_idx_q  <= idx_s1;
			best_x_q    <= rd_s1.x;
			best_y_q    <= rd_s1.y;
			best_z_q    <= rd_s1.z;
		end
		if (cmd.out_load) begin
			out_q.status <= cmd.out_status;
			if (cmd.out_status == ST_POPPED) begin
				out_q.out_x <= best_x_q;
				out_q.out_y <= best_y_q;
				out_q.out_z <= best_z_q;
			end else begin
				out_q.out_x <= '0;
				out_q.out_y <= '0;
				out_q.out_z <= '0;
			end
		end
	end

	always_comb begin
		stat.op_pop   = op_pop_q;
		stat.scan_end = (rd_idx_q == used_q);
		stat.hit      = hit_q;
		stat.found    = found_q;
		stat.full     = (used_q == CNT_W'(CAPACITY));
		stat.out_busy = out_valid_q;
	end

	assign out_data  = out_q;
	assign out_valid = out_valid_q;

endmodule

// ===== rtl/nolt_ctrl.sv =====
// nolt_ctrl: sequencer for accept, distance squaring, slot scan and commit.
// Commands nolt_datapath through ctrl_cmd_t; uses nolt_pkg.

module nolt_ctrl
	import nolt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  dp_stat_t  stat,
	output ctrl_cmd_t cmd
);

	ctrl_state_t state_q, state_d;
	logic [1:0]  sq_cnt_q;
	logic        sq_last;

	assign sq_last = (sq_cnt_q == 2'(SQ_TERMS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			sq_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_SQ && !sq_last) begin
				sq_cnt_q <= sq_cnt_q + 1'b1;
			end else begin
				sq_cnt_q <= '0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				// a pop passes through S_SQ without squaring
				if (in_valid) begin
					state_d = S_SQ;
				end
			end
			S_SQ: begin
				if (stat.op_pop || sq_last) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (stat.scan_end) begin
					state_d = S_COMMIT;
				end
			end
			S_COMMIT: begin
				if (!stat.out_busy) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready       = 1'b0;
		cmd            = '0;
		cmd.sq_sel     = sq_cnt_q;
		cmd.out_status = ST_ADDED;
		unique case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
			end
			S_SQ: begin
				cmd.sq_en = !stat.op_pop;
			end
			S_SCAN: begin
				cmd.scan_issue = !stat.scan_end;
			end
			S_COMMIT: begin
				cmd.out_load = !stat.out_busy;
				if (stat.op_pop) begin
					cmd.out_status = stat.found ? ST_POPPED : ST_EMPTY;
					cmd.commit_pop = !stat.out_busy && stat.found;
				end else if (stat.hit) begin
					cmd.out_status = ST_KNOWN;
				end else if (stat.full) begin
					cmd.out_status = ST_FULL;
				end else begin
					cmd.out_status = ST_ADDED;
					cmd.commit_add = !stat.out_busy;
				end
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

// ===== rtl/nearest_open_location_table_top.sv =====
// nearest_open_location_table_top: open/closed point list for best-first search.
// Instantiates nolt_ctrl and nolt_datapath; uses nolt_pkg and nolt_stream_if.
//
//  channel  dir  type        word
//  in_ch    in   in_item_t   cmd, point_x/y/z, goal_x/y/z
//  out_ch   out  out_item_t  status, out_x/y/z
//
// One word at a time. The scan of an add or a pop grows with used, the number
// of stored slots: the slot memory has one read port and the scan reads one
// slot per cycle. An add also squares its three axis differences in turn on
// the shared squarer. Reset empties the table at once; no clearing pass.
// A result waits in the output register while the next word is taken in;
// commit stalls only if that register is still full.

module nearest_open_location_table_top
	import nolt_pkg::*;
#(
	parameter int CAPACITY = NOLT_CAPACITY
) (
	input logic           clk,
	input logic           arst_n,
	nolt_stream_if.sink   in_ch,
	nolt_stream_if.source out_ch
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;
	logic      in_ready;
	logic      out_valid;
	out_item_t out_data;

	nolt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	nolt_datapath #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_data   (in_ch.data),
		.out_ready (out_ch.ready),
		.stat      (stat),
		.out_data  (out_data),
		.out_valid (out_valid)
	);

	assign in_ch.ready  = in_ready;
	assign out_ch.valid = out_valid;
	assign out_ch.data  = out_data;

	a_add_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit_add |-> !stat.full && !stat.hit)
		else $error("slot written while table full or point known");

	a_pop_found: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit_pop |-> stat.found && stat.op_pop)
		else $error("slot closed without an open candidate");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !out_ch.valid)
		else $error("result register overwritten");

	a_out_follows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_ch.valid)
		else $error("loaded result not presented");

endmodule

// ===== dv/nearest_open_location_table_top_test.sv =====
`timescale 1ns / 100ps
// Testbench for nearest_open_location_table_top: directed and random add/pop words,
// checked against an in-bench open/closed list. Uses nolt_pkg and nolt_stream_if.

module nearest_open_location_table_top_test
	import nolt_pkg::*;
();

	localparam int CAPACITY    = NOLT_CAPACITY;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 500;
	localparam int DRAIN_TAIL  = 80;

	logic clk;
	logic arst_n;

	nolt_stream_if #(.T(in_item_t))  in_ch ();
	nolt_stream_if #(.T(out_item_t)) out_ch ();

	nearest_open_location_table_top #(
		.CAPACITY(CAPACITY)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// mirror of the table
	logic [15:0]       tab_x [CAPACITY];
	logic [15:0]       tab_y [CAPACITY];
	logic [15:0]       tab_z [CAPACITY];
	logic [DIST_W-1:0] tab_dist [CAPACITY];
	bit                tab_open [CAPACITY];
	int                tab_used;

	out_item_t pending_results[$];

	int  snd_idle_pct;
	int  rcv_idle_pct;
	int  mismatches;
	int  cycle_count = 0;
	int  hold_cnt = 0;
	logic hold_req = 1'b0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic logic [DIST_W-1:0] sq_dist(input in_item_t w);
		longint dx;
		longint dy;
		longint dz;
		dx = longint'($signed(w.goal_x)) - longint'($signed(w.point_x));
		dy = longint'($signed(w.goal_y)) - longint'($signed(w.point_y));
		dz = longint'($signed(w.goal_z)) - longint'($signed(w.point_z));
		return DIST_W'(dx * dx + dy * dy + dz * dz);
	endfunction

	// Applies one word to the mirror and returns the result it must produce.
	function automatic out_item_t apply_to_table(input in_item_t w);
		out_item_t r;
		int best;
		r = '0;
		if (w.cmd == CMD_ADD) begin
			for (int i = 0; i < tab_used; i++) begin
				if (tab_x[i] == w.point_x && tab_y[i] == w.point_y &&
					tab_z[i] == w.point_z) begin
					r.status = ST_KNOWN;
					return r;
				end
			end
			if (tab_used >= CAPACITY) begin
				r.status = ST_FULL;
				return r;
			end
			tab_x[tab_used]    = w.point_x;
			tab_y[tab_used]    = w.point_y;
			tab_z[tab_used]    = w.point_z;
			tab_dist[tab_used] = sq_dist(w);
			tab_open[tab_used] = 1'b1;
			tab_used++;
			r.status = ST_ADDED;
		end else begin
			best = -1;
			// strict less-than keeps the earliest slot on equal distance
			for (int i = 0; i < tab_used; i++) begin
				if (tab_open[i] && (best < 0 || tab_dist[i] < tab_dist[best]))
					best = i;
			end
			if (best < 0) begin
				r.status = ST_EMPTY;
				return r;
			end
			tab_open[best] = 1'b0;
			r.status = ST_POPPED;
			r.out_x  = tab_x[best];
			r.out_y  = tab_y[best];
			r.out_z  = tab_z[best];
		end
		return r;
	endfunction

	function automatic in_item_t make_add(input logic [15:0] px, py, pz, gx, gy, gz);
		in_item_t w;
		w.cmd     = CMD_ADD;
		w.point_x = px;
		w.point_y = py;
		w.point_z = pz;
		w.goal_x  = gx;
		w.goal_y  = gy;
		w.goal_z  = gz;
		return w;
	endfunction

	// point and goal fields are don't-care on a pop, so fill them with noise
	function automatic in_item_t make_pop();
		in_item_t w;
		w = make_add(16'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom), 16'($urandom), 16'($urandom));
		w.cmd = CMD_POP;
		return w;
	endfunction

	function automatic logic [15:0] pick_coord();
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] near_coord();
		return 16'($urandom_range(6)) - 16'd3;
	endfunction

	task automatic send_word(input in_item_t w);
		while ($urandom_range(99) < snd_idle_pct) begin
			if (in_ch.valid)
				in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.data <= w;
		if (!in_ch.valid)
			in_ch.valid <= 1'b1;
		do
			@(posedge clk);
		while (!in_ch.ready);
		pending_results = {pending_results, apply_to_table(w)};
	endtask

	// result side: check, then pick ready for the next cycle
	always @(posedge clk) begin : out_side
		out_item_t want;
		out_item_t got;
		got = out_ch.data;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_results.size() == 0) begin
				mismatches = mismatches + 1;
				if (mismatches <= 10)
					$display("unexpected result word: status %0d xyz %0d %0d %0d",
						got.status, got.out_x, got.out_y, got.out_z);
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status || got.out_x !== want.out_x ||
					got.out_y !== want.out_y || got.out_z !== want.out_z) begin
					mismatches = mismatches + 1;
					if (mismatches <= 10)
						$display("result mismatch: expected status %0d xyz %0d %0d %0d,",
							want.status, want.out_x, want.out_y, want.out_z,
							" got status %0d xyz %0d %0d %0d",
							got.status, got.out_x, got.out_y, got.out_z);
				end
			end
		end
		out_ch.ready <= !hold_req && ($urandom_range(99) >= rcv_idle_pct);
	end

	// long receiver hold-off, counted here
	always @(posedge clk) begin
		if (hold_req) begin
			if (hold_cnt == HOLD_CYCLES) begin
				hold_req <= 1'b0;
				hold_cnt <= 0;
			end else begin
				hold_cnt <= hold_cnt + 1;
			end
		end
	end

	task automatic test_directed();
		send_word(make_pop());
		// farthest possible point, then a point sitting on its goal
		send_word(make_add(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF));
		send_word(make_add(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
		send_word(make_add(16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'h0000, 16'h0000));
		// three points at equal distance
		send_word(make_add(16'd1, 16'd2, 16'd3, 16'd0, 16'd0, 16'd0));
		send_word(make_add(-16'd1, -16'd2, -16'd3, 16'd0, 16'd0, 16'd0));
		send_word(make_add(16'd3, 16'd2, 16'd1, 16'd0, 16'd0, 16'd0));
		repeat (6)
			send_word(make_pop());
		// closed point is still known
		send_word(make_add(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h1234, 16'h0000, 16'hFFFF));
		send_word(make_add(16'h7FFF, 16'h7FFF, 16'h7FFE, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		send_word(make_add(16'hFFFF, 16'h0000, 16'h5555, 16'hAAAA, 16'h8000, 16'h7FFF));
		send_word(make_pop());
		send_word(make_pop());
		send_word(make_pop());
	endtask

	task automatic test_random_mix(input int count);
		int sel;
		int idx;
		for (int k = 0; k < count; k++) begin
			sel = $urandom_range(99);
			if (sel < 30) begin
				send_word(make_pop());
			end else if (sel < 55 && tab_used > 0) begin
				idx = $urandom_range(tab_used - 1);
				send_word(make_add(tab_x[idx], tab_y[idx], tab_z[idx],
					pick_coord(), pick_coord(), pick_coord()));
			end else if (sel < 80) begin
				// tight cluster: many repeats and equal distances
				send_word(make_add(near_coord(), near_coord(), near_coord(),
					near_coord(), near_coord(), near_coord()));
			end else begin
				send_word(make_add(pick_coord(), pick_coord(), pick_coord(),
					pick_coord(), pick_coord(), pick_coord()));
			end
		end
	endtask

	task automatic test_output_backpressure();
		snd_idle_pct = 0;
		hold_req <= 1'b1;
		for (int k = 0; k < 12; k++) begin
			if (k % 3 == 2)
				send_word(make_pop());
			else
				send_word(make_add(near_coord(), near_coord(), pick_coord(),
					pick_coord(), near_coord(), near_coord()));
		end
	endtask

	task automatic test_table_full();
		while (tab_used < CAPACITY)
			send_word(make_add(16'($urandom), 16'($urandom), 16'($urandom),
				pick_coord(), pick_coord(), pick_coord()));
		send_word(make_add(16'($urandom), 16'($urandom), 16'($urandom),
			16'd0, 16'd0, 16'd0));
		// known wins over full
		send_word(make_add(tab_x[CAPACITY-1], tab_y[CAPACITY-1], tab_z[CAPACITY-1],
			16'd0, 16'd0, 16'd0));
		send_word(make_add(tab_x[0], tab_y[0], tab_z[0], 16'h7FFF, 16'h8000, 16'd0));
		repeat (CAPACITY + 2)
			send_word(make_pop());
	endtask

	initial begin
		arst_n       = 1'b0;
		in_ch.valid  = 1'b0;
		in_ch.data   = '0;
		mismatches   = 0;
		tab_used     = 0;
		snd_idle_pct = 33;
		rcv_idle_pct = 52;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random_mix(100);
		snd_idle_pct = 52;
		rcv_idle_pct = 33;
		test_random_mix(100);
		test_output_backpressure();
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		test_random_mix(100);
		test_table_full();

		if (in_ch.valid)
			in_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_TAIL) @(posedge clk);

		if (mismatches == 0 && pending_results.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
